>>> rtl/core/gregorian_date_arithmetic_defines.svh
// Assertion macros for the Gregorian date arithmetic block.
// Needs nothing; taken in by files that assert.
`ifndef GREGORIAN_DATE_ARITHMETIC_DEFINES_SVH
`define GREGORIAN_DATE_ARITHMETIC_DEFINES_SVH

// Same-cycle implication under reset.
`define GDA_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("gda assertion failed");

// Next-cycle implication under reset.
`define GDA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("gda assertion failed");

`endif

>>> rtl/core/gda_pkg.sv
// Shared types, constants and calendar tables of the date arithmetic block.
// Depends on nothing.
package gda_pkg;

	localparam int COUNT_WIDTH_DEF = 17;
	localparam int NUM_W           = 21;  // day number of a date up to year 4095
	localparam int CFG_IDX_W       = 2;
	localparam logic [11:0] MIN_YEAR_RESET = 12'd1900;
	localparam logic [11:0] MAX_YEAR_RESET = 12'd2200;
	localparam int YEAR_SHIFT = 400;

	typedef enum logic [1:0] {
		ACT_ADD = 2'd0,
		ACT_SUB = 2'd1,
		ACT_CMP = 2'd2
	} action_t;

	localparam logic [1:0] ORD_EARLIER = 2'd0;
	localparam logic [1:0] ORD_EQUAL   = 2'd1;
	localparam logic [1:0] ORD_LATER   = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_MIN_YEAR = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_YEAR = 2'd1;

	// First day of each month in a year that starts on 1 March.
	function automatic logic [8:0] mp_start(input logic [3:0] mp);
		logic [8:0] s;
		case (mp)
			4'd0:    s = 9'd0;
			4'd1:    s = 9'd31;
			4'd2:    s = 9'd61;
			4'd3:    s = 9'd92;
			4'd4:    s = 9'd122;
			4'd5:    s = 9'd153;
			4'd6:    s = 9'd184;
			4'd7:    s = 9'd214;
			4'd8:    s = 9'd245;
			4'd9:    s = 9'd275;
			4'd10:   s = 9'd306;
			4'd11:   s = 9'd337;
			default: s = 9'd0;
		endcase
		return s;
	endfunction

	// Last day of a month in a common year; zero for a month code that means nothing.
	function automatic logic [4:0] month_last(input logic [3:0] m);
		logic [4:0] l;
		case (m)
			4'd2:                            l = 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11:         l = 5'd30;
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8,
			4'd10, 4'd12:                    l = 5'd31;
			default:                         l = 5'd0;
		endcase
		return l;
	endfunction

endpackage

>>> rtl/core/gda_if.sv
// Channel interfaces of the date arithmetic block: items, results, config writes.
// Depends on gda_pkg.
interface gda_item_if #(parameter int COUNT_WIDTH = gda_pkg::COUNT_WIDTH_DEF);
	import gda_pkg::*;
	logic                   valid;
	logic                   ready;
	logic [1:0]             action;
	logic [4:0]             day;
	logic [3:0]             month;
	logic [11:0]            year;
	logic [COUNT_WIDTH-1:0] day_count;
	logic [4:0]             second_day;
	logic [3:0]             second_month;
	logic [11:0]            second_year;

	modport source (output valid, action, day, month, year, day_count,
		second_day, second_month, second_year, input ready);
	modport sink (input valid, action, day, month, year, day_count,
		second_day, second_month, second_year, output ready);
endinterface

interface gda_result_if;
	logic        valid;
	logic        ready;
	logic [4:0]  out_day;
	logic [3:0]  out_month;
	logic [11:0] out_year;
	logic [2:0]  weekday;
	logic        leap_year;
	logic        date_valid;
	logic [1:0]  order;
	logic [16:0] day_difference;
	logic [11:0] month_difference;
	logic [11:0] year_difference;

	modport source (output valid, out_day, out_month, out_year, weekday, leap_year,
		date_valid, order, day_difference, month_difference, year_difference,
		input ready);
	modport sink (input valid, out_day, out_month, out_year, weekday, leap_year,
		date_valid, order, day_difference, month_difference, year_difference,
		output ready);
endinterface

interface gda_cfg_if;
	import gda_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [11:0]          data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/core/gda_to_days.sv
// Date to day number in two stages, with validity and leap flag.
// Depends on gda_pkg.
module gda_to_days (
	input  logic                      clk,
	input  logic                      en,
	input  logic [4:0]                day,
	input  logic [3:0]                month,
	input  logic [11:0]               year,
	input  logic [11:0]               min_year,
	input  logic [11:0]               max_year,
	output logic [gda_pkg::NUM_W-1:0] num,
	output logic                      ok,
	output logic                      leap
);
	import gda_pkg::*;

	localparam int K_YS = 20;
	localparam longint unsigned R_YS = ((64'd1 << K_YS) + 64'd99) / 64'd100;
	localparam int RW_YS = $clog2(R_YS + 1);
	localparam int K_Y = 19;
	localparam longint unsigned R_Y = ((64'd1 << K_Y) + 64'd99) / 64'd100;
	localparam int RW_Y = $clog2(R_Y + 1);

	logic [12:0]          ys;
	logic [3:0]           mp;
	logic [13+RW_YS-1:0]  prod_ys;
	logic [12+RW_Y-1:0]   prod_y;

	logic [12:0] ys_s1;
	logic [6:0]  q_ys_s1;
	logic [5:0]  q_y_s1;
	logic [11:0] y_s1;
	logic [4:0]  d_s1;
	logic [8:0]  base_s1;
	logic        basic_ok_s1, len_ok_s1, feb29_s1, range_ok_s1;

	logic [11:0] r100;
	logic        leap_c;

	always_comb begin
		ys = 13'(year) + 13'(YEAR_SHIFT) - ((month <= 4'd2) ? 13'd1 : 13'd0);
		mp = (month > 4'd2) ? 4'(month - 4'd3) : 4'(month + 4'd9);
		prod_ys = (13+RW_YS)'(ys) * (13+RW_YS)'(R_YS);
		prod_y  = (12+RW_Y)'(year) * (12+RW_Y)'(R_Y);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ys_s1       <= ys;
			q_ys_s1     <= prod_ys[K_YS+6:K_YS];
			q_y_s1      <= prod_y[K_Y+5:K_Y];
			y_s1        <= year;
			d_s1        <= day;
			base_s1     <= mp_start(mp);
			basic_ok_s1 <= (day != 5'd0) && (month != 4'd0) && (month <= 4'd12);
			len_ok_s1   <= day <= month_last(month);
			feb29_s1    <= (month == 4'd2) && (day == 5'd29);
			range_ok_s1 <= (year >= min_year) && (year <= max_year);
		end
	end

	always_comb begin
		r100   = y_s1 - 12'(q_y_s1) * 12'd100;
		leap_c = (y_s1[1:0] == 2'd0) && ((r100 != 12'd0) || (q_y_s1[1:0] == 2'd0));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			leap <= leap_c;
			ok   <= basic_ok_s1 && range_ok_s1 && (len_ok_s1 || (feb29_s1 && leap_c));
			num  <= NUM_W'(ys_s1) * NUM_W'(365) + NUM_W'(ys_s1 >> 2) - NUM_W'(q_ys_s1)
				+ NUM_W'(q_ys_s1 >> 2) + NUM_W'(base_s1) + NUM_W'(d_s1) - NUM_W'(1);
		end
	end

endmodule

>>> rtl/core/gda_from_days.sv
// Day number back to day, month and shifted year over eight stages.
// Depends on gda_pkg.
module gda_from_days #(
	parameter int COUNT_WIDTH = gda_pkg::COUNT_WIDTH_DEF
) (
	input  logic                                       clk,
	input  logic                                       en,
	input  logic [((COUNT_WIDTH > gda_pkg::NUM_W) ? COUNT_WIDTH : gda_pkg::NUM_W):0] z,
	output logic [4:0]                                 day,
	output logic [3:0]                                 month,
	output logic [$clog2(400 + ((2 ** (((COUNT_WIDTH > gda_pkg::NUM_W) ?
		COUNT_WIDTH : gda_pkg::NUM_W) + 1)) - 1) / 146097 * 400 + 2) - 1:0] ys
);
	import gda_pkg::*;

	localparam int ZW   = ((COUNT_WIDTH > NUM_W) ? COUNT_WIDTH : NUM_W) + 1;
	localparam longint unsigned DaysEra = 64'd146097;
	localparam int EMAX = ((2 ** ZW) - 1) / 146097;
	localparam int EW   = $clog2(EMAX + 1);
	localparam int YSW  = $clog2(400 + EMAX * 400 + 2);

	localparam int K_E = ZW + 18;
	localparam longint unsigned R_E = ((64'd1 << K_E) + DaysEra - 64'd1) / DaysEra;
	localparam int RW_E = $clog2(R_E + 1);
	localparam int K_D = 36;
	localparam longint unsigned R_A = ((64'd1 << K_D) + 64'd1459) / 64'd1460;
	localparam longint unsigned R_B = ((64'd1 << K_D) + 64'd36523) / 64'd36524;
	localparam longint unsigned R_C = ((64'd1 << K_D) + 64'd146095) / 64'd146096;
	localparam int RW_D = $clog2(R_A + 1);
	localparam int K_T = 27;
	localparam longint unsigned R_T = ((64'd1 << K_T) + 64'd364) / 64'd365;
	localparam int RW_T = $clog2(R_T + 1);
	localparam int K_H = 16;
	localparam longint unsigned R_H = ((64'd1 << K_H) + 64'd99) / 64'd100;
	localparam int RW_H = $clog2(R_H + 1);

	logic [ZW+RW_E-1:0] prod_e;
	logic [18+RW_D-1:0] prod_a, prod_b, prod_c;
	logic [18+RW_T-1:0] prod_t;
	logic [9+RW_H-1:0]  prod_h;

	logic [ZW-1:0] z_s4;
	logic [EW-1:0] era_s4, era_s5, era_s6, era_s7, era_s8, era_s9, era_s10;
	logic [17:0]   doe_s5, doe_s6, doe_s7, doe_s8, doe_s9;
	logic [7:0]    a_s6;
	logic [1:0]    b_s6;
	logic          c_s6;
	logic [17:0]   t_s7;
	logic [8:0]    yoe_s8, yoe_s9, yoe_s10;
	logic [17:0]   p_s9;
	logic [1:0]    h_s9;
	logic [8:0]    doy_s10;

	logic [3:0] mp;
	logic [3:0] m_c;

	always_comb begin
		prod_e = (ZW+RW_E)'(z) * (ZW+RW_E)'(R_E);
		prod_a = (18+RW_D)'(doe_s5) * (18+RW_D)'(R_A);
		prod_b = (18+RW_D)'(doe_s5) * (18+RW_D)'(R_B);
		prod_c = (18+RW_D)'(doe_s5) * (18+RW_D)'(R_C);
		prod_t = (18+RW_T)'(t_s7) * (18+RW_T)'(R_T);
		prod_h = (9+RW_H)'(yoe_s8) * (9+RW_H)'(R_H);
	end

	always_comb begin
		mp = 4'd0;
		for (int i = 1; i < 12; i++) begin
			if (doy_s10 >= mp_start(4'(i)))
				mp = 4'(i);
		end
		m_c = (mp < 4'd10) ? 4'(mp + 4'd3) : 4'(mp - 4'd9);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// era quotient, exact over the whole input range
			z_s4    <= z;
			era_s4  <= prod_e[K_E+EW-1:K_E];
			doe_s5  <= 18'(z_s4 - ZW'(era_s4) * ZW'(DaysEra));
			era_s5  <= era_s4;
			a_s6    <= prod_a[K_D+7:K_D];
			b_s6    <= prod_b[K_D+1:K_D];
			c_s6    <= prod_c[K_D];
			doe_s6  <= doe_s5;
			era_s6  <= era_s5;
			t_s7    <= doe_s6 - 18'(a_s6) + 18'(b_s6) - 18'(c_s6);
			doe_s7  <= doe_s6;
			era_s7  <= era_s6;
			yoe_s8  <= prod_t[K_T+8:K_T];
			doe_s8  <= doe_s7;
			era_s8  <= era_s7;
			p_s9    <= 18'(yoe_s8) * 18'(365) + 18'(yoe_s8 >> 2);
			h_s9    <= prod_h[K_H+1:K_H];
			yoe_s9  <= yoe_s8;
			doe_s9  <= doe_s8;
			era_s9  <= era_s8;
			doy_s10 <= 9'(doe_s9 - p_s9 + 18'(h_s9));
			yoe_s10 <= yoe_s9;
			era_s10 <= era_s9;
			day     <= 5'(doy_s10 - mp_start(mp) + 9'd1);
			month   <= m_c;
			ys      <= YSW'(yoe_s10) + YSW'(era_s10) * YSW'(400)
				+ ((m_c <= 4'd2) ? YSW'(1) : YSW'(0));
		end
	end

endmodule

>>> rtl/core/gregorian_date_arithmetic.sv
// Top level of the Gregorian date arithmetic block: add, subtract, compare.
// Depends on gda_pkg, gda_if, gda_to_days, gda_from_days and the defines header.
//
//   channel  dir  beat carries
//   cfg      in   register index, 12-bit year limit
//   item     in   action, first date, day count, second date
//   result   out  new date, weekday, leap, valid, order, differences
//
// One item per cycle while no result beat waits; each beat passes the day number to
// date conversion (eight stages of constant-divisor multiplies) on its way to the
// result. The whole pipeline advances together: it holds while a result
// beat waits and item ready follows that. Reset clears the valid bits and
// loads the year limits 1900 and 2200; cfg is always ready.
`include "gregorian_date_arithmetic_defines.svh"
module gregorian_date_arithmetic #(
	parameter int COUNT_WIDTH = gda_pkg::COUNT_WIDTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	gda_cfg_if.sink       cfg,
	gda_item_if.sink      item,
	gda_result_if.source  result
);
	import gda_pkg::*;

	localparam int ZW   = ((COUNT_WIDTH > NUM_W) ? COUNT_WIDTH : NUM_W) + 1;
	localparam int EMAX = ((2 ** ZW) - 1) / 146097;
	localparam int YSW  = $clog2(400 + EMAX * 400 + 2);
	localparam logic [16:0] DMAX = (COUNT_WIDTH >= 17) ? 17'h1FFFF
		: 17'((64'd1 << COUNT_WIDTH) - 64'd1);
	localparam int K_W = 25;
	localparam longint unsigned R_W = ((64'd1 << K_W) + 64'd6) / 64'd7;
	localparam int RW_W = $clog2(R_W + 1);

	typedef struct packed {
		logic [1:0]             action;
		logic [COUNT_WIDTH-1:0] cnt;
		logic [4:0]             d1;
		logic [3:0]             m1;
		logic [11:0]            y1;
		logic [3:0]             m2;
		logic [11:0]            y2;
	} pay_t;

	typedef struct packed {
		logic        ok1;
		logic        leap;
		logic        addsub;
		logic        zok;
		logic        cmp_ok;
		logic [1:0]  order;
		logic [16:0] dd;
		logic [11:0] md;
		logic [11:0] yd;
		logic [2:0]  wd;
		logic [4:0]  d1;
		logic [3:0]  m1;
		logic [11:0] y1;
	} side_t;

	logic [11:0] min_year_q, max_year_q;
	logic        adv, accept;
	logic [12:1] vld_s;

	pay_t pay_s1, pay_s2;
	logic [NUM_W-1:0] n1, n2;
	logic ok1, ok2, leap1, leap2;

	// stage 3
	logic [ZW-1:0]    z_c;
	logic             zok_c;
	logic [NUM_W-1:0] ndiff;
	logic [15:0]      ma, mb, mdiff;
	logic [NUM_W-1:0] wx;
	logic [NUM_W+RW_W-1:0] prod_w;
	logic [ZW-1:0]    z_s3;
	side_t            side_s3;
	logic [NUM_W-1:0] wx_s3;
	logic [NUM_W-1:0] wq_s3;
	side_t            side_wd;
	side_t            side_s [4:11];

	logic [4:0]     fd_day;
	logic [3:0]     fd_month;
	logic [YSW-1:0] fd_ys;
	logic           res_ok;

	assign adv        = !vld_s[12] || result.ready;
	assign item.ready = adv;
	assign accept     = item.valid && adv;
	assign cfg.ready  = 1'b1;
	assign result.valid = vld_s[12];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_year_q <= MIN_YEAR_RESET;
			max_year_q <= MAX_YEAR_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_MIN_YEAR: min_year_q <= cfg.data;
				REG_MAX_YEAR: max_year_q <= cfg.data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s <= '0;
		else if (adv)
			vld_s <= {vld_s[11:1], accept};
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pay_s1 <= '{action: item.action, cnt: item.day_count, d1: item.day,
				m1: item.month, y1: item.year, m2: item.second_month, y2: item.second_year};
			pay_s2 <= pay_s1;
		end
	end

	gda_to_days u_first (
		.clk(clk), .en(adv), .day(item.day), .month(item.month), .year(item.year),
		.min_year(min_year_q), .max_year(max_year_q), .num(n1), .ok(ok1), .leap(leap1)
	);

	gda_to_days u_second (
		.clk(clk), .en(adv), .day(item.second_day), .month(item.second_month),
		.year(item.second_year), .min_year(min_year_q), .max_year(max_year_q),
		.num(n2), .ok(ok2), .leap(leap2)
	);

	always_comb begin
		zok_c = 1'b0;
		z_c   = ZW'(n1) + ZW'(pay_s2.cnt);
		case (pay_s2.action)
			ACT_ADD: zok_c = 1'b1;
			ACT_SUB: begin
				z_c   = ZW'(n1) - ZW'(pay_s2.cnt);
				zok_c = ZW'(pay_s2.cnt) <= ZW'(n1);
			end
			default: zok_c = 1'b0;
		endcase
		ndiff  = (n1 > n2) ? n1 - n2 : n2 - n1;
		ma     = 16'(pay_s2.y1) * 16'd12 + 16'(pay_s2.m1);
		mb     = 16'(pay_s2.y2) * 16'd12 + 16'(pay_s2.m2);
		mdiff  = (ma > mb) ? ma - mb : mb - ma;
		wx     = n1 + NUM_W'(3);
		prod_w = (NUM_W+RW_W)'(wx) * (NUM_W+RW_W)'(R_W);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			z_s3            <= z_c;
			wx_s3           <= wx;
			wq_s3           <= NUM_W'(prod_w >> K_W);
			side_s3.ok1     <= ok1;
			side_s3.leap    <= leap1;
			side_s3.addsub  <= (pay_s2.action == ACT_ADD) || (pay_s2.action == ACT_SUB);
			side_s3.zok     <= zok_c;
			side_s3.cmp_ok  <= (pay_s2.action == ACT_CMP) && ok2;
			side_s3.order   <= (n1 < n2) ? ORD_EARLIER : (n1 == n2) ? ORD_EQUAL : ORD_LATER;
			side_s3.dd      <= (ndiff > NUM_W'(DMAX)) ? DMAX : 17'(ndiff);
			side_s3.md      <= (mdiff > 16'd4095) ? 12'd4095 : 12'(mdiff);
			side_s3.yd      <= (pay_s2.y1 > pay_s2.y2) ? pay_s2.y1 - pay_s2.y2
				: pay_s2.y2 - pay_s2.y1;
			side_s3.wd      <= 3'd0;
			side_s3.d1      <= pay_s2.d1;
			side_s3.m1      <= pay_s2.m1;
			side_s3.y1      <= pay_s2.y1;
		end
	end

	// weekday remainder; drop it into the side band and carry it along
	always_comb begin
		side_wd    = side_s3;
		side_wd.wd = 3'(wx_s3 - wq_s3 * NUM_W'(7)) + 3'd1;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s[4] <= side_wd;
			for (int i = 5; i <= 11; i++)
				side_s[i] <= side_s[i-1];
		end
	end

	gda_from_days #(.COUNT_WIDTH(COUNT_WIDTH)) u_from (
		.clk(clk), .en(adv), .z(z_s3), .day(fd_day), .month(fd_month), .ys(fd_ys)
	);

	always_comb begin
		if (side_s[11].addsub)
			res_ok = side_s[11].ok1 && side_s[11].zok
				&& (fd_ys >= YSW'(min_year_q) + YSW'(YEAR_SHIFT))
				&& (fd_ys <= YSW'(max_year_q) + YSW'(YEAR_SHIFT));
		else
			res_ok = side_s[11].ok1 && side_s[11].cmp_ok;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			result.leap_year  <= side_s[11].leap;
			result.date_valid <= res_ok;
			result.weekday    <= res_ok ? side_s[11].wd : 3'd0;
			if (res_ok && side_s[11].addsub) begin
				result.out_day   <= fd_day;
				result.out_month <= fd_month;
				result.out_year  <= 12'(fd_ys - YSW'(YEAR_SHIFT));
			end else if (res_ok) begin
				result.out_day   <= side_s[11].d1;
				result.out_month <= side_s[11].m1;
				result.out_year  <= side_s[11].y1;
			end else begin
				result.out_day   <= 5'd0;
				result.out_month <= 4'd0;
				result.out_year  <= 12'd0;
			end
			if (res_ok && !side_s[11].addsub) begin
				result.order            <= side_s[11].order;
				result.day_difference   <= side_s[11].dd;
				result.month_difference <= side_s[11].md;
				result.year_difference  <= side_s[11].yd;
			end else begin
				result.order            <= ORD_EARLIER;
				result.day_difference   <= 17'd0;
				result.month_difference <= 12'd0;
				result.year_difference  <= 12'd0;
			end
		end
	end

	`GDA_ASSERT_IMPLY(a_invalid_zero, clk, arst_n, result.valid && !result.date_valid,
		result.out_day == 5'd0 && result.weekday == 3'd0 && result.day_difference == 17'd0)
	`GDA_ASSERT_IMPLY(a_valid_date, clk, arst_n, result.valid && result.date_valid,
		result.weekday != 3'd0 && result.out_month != 4'd0 && result.out_month <= 4'd12)
	`GDA_ASSERT_NEXT(a_stall_hold, clk, arst_n, !adv, $stable(vld_s))

endmodule

>>> verif/gregorian_date_arithmetic_test.sv
// Self-checking bench for gregorian_date_arithmetic: directed and random dates,
// predicted in-bench and compared beat by beat. Needs gda_pkg, gda_if and the RTL.
`timescale 1ns / 1ps
module gregorian_date_arithmetic_test;
	import gda_pkg::*;

	localparam int CW = 17;
	localparam longint unsigned DAY_SAT = (64'd1 << CW) - 1;

	typedef struct {
		logic [1:0]    action;
		logic [4:0]    day;
		logic [3:0]    month;
		logic [11:0]   year;
		logic [CW-1:0] day_count;
		logic [4:0]    second_day;
		logic [3:0]    second_month;
		logic [11:0]   second_year;
	} date_item_t;

	typedef struct {
		logic [4:0]  out_day;
		logic [3:0]  out_month;
		logic [11:0] out_year;
		logic [2:0]  weekday;
		logic        leap_year;
		logic        date_valid;
		logic [1:0]  order;
		logic [16:0] day_difference;
		logic [11:0] month_difference;
		logic [11:0] year_difference;
	} date_result_t;

	logic clk;
	logic arst_n;

	gda_cfg_if                       cfg_ch();
	gda_item_if #(.COUNT_WIDTH(CW))  item_ch();
	gda_result_if                    result_ch();

	gregorian_date_arithmetic #(.COUNT_WIDTH(CW)) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch.sink),
		.item   (item_ch.sink),
		.result (result_ch.source)
	);

	// bench copy of the year limits
	logic [11:0] lim_min_year = MIN_YEAR_RESET;
	logic [11:0] lim_max_year = MAX_YEAR_RESET;

	date_result_t expected_dates[$];
	int mismatches = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_off_cycles = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2ms;
		$display("status: fail");
		$finish;
	end

	function automatic bit leap_of(longint unsigned y);
		return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
	endfunction

	function automatic longint unsigned days_in_month(longint unsigned m, longint unsigned y);
		if (m == 2 && leap_of(y))
			return 29;
		return month_last(m[3:0]);
	endfunction

	function automatic bit date_in_range(longint unsigned d, longint unsigned m,
		longint unsigned y);
		if (d == 0 || m == 0 || m > 12)
			return 0;
		if (d > days_in_month(m, y))
			return 0;
		return y >= lim_min_year && y <= lim_max_year;
	endfunction

	// day number from 1 March of year -400
	function automatic longint unsigned day_number(longint unsigned d, longint unsigned m,
		longint unsigned y);
		longint unsigned ys, era, yoe, mp, doy;
		ys = y + YEAR_SHIFT - ((m <= 2) ? 1 : 0);
		era = ys / 400;
		yoe = ys - era * 400;
		mp = (m > 2) ? m - 3 : m + 9;
		doy = (153 * mp + 2) / 5 + d - 1;
		return era * 146097 + yoe * 365 + yoe / 4 - yoe / 100 + doy;
	endfunction

	function automatic void date_of_number(input longint unsigned z,
		output longint unsigned d, output longint unsigned m, output longint unsigned ys);
		longint unsigned era, doe, yoe, doy, mp;
		era = z / 146097;
		doe = z - era * 146097;
		yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
		doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
		mp = (5 * doy + 2) / 153;
		d = doy - (153 * mp + 2) / 5 + 1;
		m = (mp < 10) ? mp + 3 : mp - 9;
		ys = yoe + era * 400 + ((m <= 2) ? 1 : 0);
	endfunction

	function automatic date_result_t predict_date(date_item_t it);
		date_result_t r;
		longint unsigned n1, n2, n, d, m, ys, a, b, dd, md;
		bit ok;
		r = '{default: '0};
		r.leap_year = leap_of(it.year);
		if (date_in_range(it.day, it.month, it.year)) begin
			n1 = day_number(it.day, it.month, it.year);
			if (it.action == ACT_ADD || it.action == ACT_SUB) begin
				ok = 1;
				if (it.action == ACT_ADD)
					n = n1 + it.day_count;
				else if (it.day_count <= n1)
					n = n1 - it.day_count;
				else
					ok = 0;
				if (ok) begin
					date_of_number(n, d, m, ys);
					if (ys >= YEAR_SHIFT && ys - YEAR_SHIFT >= lim_min_year
						&& ys - YEAR_SHIFT <= lim_max_year) begin
						r.out_day = 5'(d);
						r.out_month = 4'(m);
						r.out_year = 12'(ys - YEAR_SHIFT);
						r.date_valid = 1;
					end
				end
			end else if (it.action == ACT_CMP
				&& date_in_range(it.second_day, it.second_month, it.second_year)) begin
				n2 = day_number(it.second_day, it.second_month, it.second_year);
				a = it.year * 12 + it.month;
				b = it.second_year * 12 + it.second_month;
				dd = (n1 > n2) ? n1 - n2 : n2 - n1;
				md = (a > b) ? a - b : b - a;
				r.out_day = it.day;
				r.out_month = it.month;
				r.out_year = it.year;
				r.order = (n1 < n2) ? ORD_EARLIER : (n1 == n2) ? ORD_EQUAL : ORD_LATER;
				r.day_difference = 17'((dd > DAY_SAT) ? DAY_SAT : dd);
				r.month_difference = 12'((md > 4095) ? 4095 : md);
				r.year_difference = (it.year > it.second_year) ? it.year - it.second_year
					: it.second_year - it.year;
				r.date_valid = 1;
			end
			if (r.date_valid)
				r.weekday = 3'((n1 + 3) % 7 + 1);
		end
		return r;
	endfunction

	// receiver: random stalls, plus a counted hold-off when asked
	initial begin
		result_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_cycles > 0) begin
				hold_off_cycles--;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	task automatic check_field(string name, longint unsigned exp_v, longint unsigned act_v);
		if (exp_v != act_v) begin
			$display("%0t: %s expected %0d actual %0d", $time, name, exp_v, act_v);
			mismatches++;
		end
	endtask

	// sample at the falling edge: the beat moves at the next rising edge
	initial begin
		date_result_t e;
		forever begin
			@(negedge clk);
			if (arst_n && result_ch.valid && result_ch.ready) begin
				if (expected_dates.size() == 0) begin
					$display("%0t: unexpected result beat, expected none, actual day %0d",
						$time, result_ch.out_day);
					mismatches++;
				end else begin
					e = expected_dates.pop_front();
					check_field("out_day", e.out_day, result_ch.out_day);
					check_field("out_month", e.out_month, result_ch.out_month);
					check_field("out_year", e.out_year, result_ch.out_year);
					check_field("weekday", e.weekday, result_ch.weekday);
					check_field("leap_year", e.leap_year, result_ch.leap_year);
					check_field("date_valid", e.date_valid, result_ch.date_valid);
					check_field("order", e.order, result_ch.order);
					check_field("day_difference", e.day_difference, result_ch.day_difference);
					check_field("month_difference", e.month_difference,
						result_ch.month_difference);
					check_field("year_difference", e.year_difference,
						result_ch.year_difference);
				end
			end
		end
	end

	// entered and left just after a rising edge
	task automatic send_date(date_item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			item_ch.valid <= 1'b0;
			@(posedge clk);
		end
		item_ch.valid        <= 1'b1;
		item_ch.action       <= it.action;
		item_ch.day          <= it.day;
		item_ch.month        <= it.month;
		item_ch.year         <= it.year;
		item_ch.day_count    <= it.day_count;
		item_ch.second_day   <= it.second_day;
		item_ch.second_month <= it.second_month;
		item_ch.second_year  <= it.second_year;
		do @(negedge clk); while (!item_ch.ready);
		expected_dates.push_back(predict_date(it));
		@(posedge clk);
	endtask

	task automatic drain_results();
		item_ch.valid <= 1'b0;
		@(posedge clk);
		while (expected_dates.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	task automatic write_year_limit(logic [CFG_IDX_W-1:0] idx, logic [11:0] value);
		drain_results();
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= value;
		do @(negedge clk); while (!cfg_ch.ready);
		if (idx == REG_MIN_YEAR)
			lim_min_year = value;
		else
			lim_max_year = value;
		@(posedge clk);
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic date_item_t make_item(logic [1:0] act, int d, int m, int y,
		int cnt, int d2, int m2, int y2);
		date_item_t it;
		it.action = act;
		it.day = 5'(d);
		it.month = 4'(m);
		it.year = 12'(y);
		it.day_count = CW'(cnt);
		it.second_day = 5'(d2);
		it.second_month = 4'(m2);
		it.second_year = 12'(y2);
		return it;
	endfunction

	function automatic void pick_date(output logic [4:0] d, output logic [3:0] m,
		output logic [11:0] y);
		int lo, hi;
		lo = lim_min_year;
		hi = (lim_max_year >= lim_min_year) ? lim_max_year : lim_min_year;
		y = 12'($urandom_range(hi, lo));
		m = 4'($urandom_range(12, 1));
		d = 5'($urandom_range(32'(days_in_month(m, y)), 1));
	endfunction

	function automatic date_item_t random_date_item();
		date_item_t it;
		it.action       = 2'($urandom_range(3));
		it.day          = 5'($urandom);
		it.month        = 4'($urandom);
		it.year         = 12'($urandom);
		it.day_count    = CW'($urandom);
		it.second_day   = 5'($urandom);
		it.second_month = 4'($urandom);
		it.second_year  = 12'($urandom);
		// mostly well-formed dates so that the arithmetic is reached
		if ($urandom_range(99) < 85) begin
			pick_date(it.day, it.month, it.year);
			pick_date(it.second_day, it.second_month, it.second_year);
			if ($urandom_range(9) != 0)
				it.action = 2'($urandom_range(ACT_CMP, ACT_ADD));
			case ($urandom_range(2))
				0: it.day_count = CW'($urandom_range(400));
				1: it.day_count = CW'($urandom_range(40000));
				default: ;
			endcase
		end
		return it;
	endfunction

	task automatic run_random(int count, int idle_pct, int stall_pct);
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		repeat (count) send_date(random_date_item());
		drain_results();
	endtask

	task automatic test_default_limits();
		send_date(make_item(ACT_ADD, 1, 1, 1900, 0, 0, 0, 0));
		send_date(make_item(ACT_ADD, 28, 2, 2000, 1, 0, 0, 0));
		send_date(make_item(ACT_ADD, 28, 2, 1900, 1, 0, 0, 0));
		send_date(make_item(ACT_ADD, 29, 2, 1900, 0, 0, 0, 0));
		send_date(make_item(ACT_ADD, 29, 2, 2024, 365, 0, 0, 0));
		send_date(make_item(ACT_ADD, 0, 5, 2000, 3, 0, 0, 0));
		send_date(make_item(ACT_ADD, 5, 0, 2000, 3, 0, 0, 0));
		send_date(make_item(ACT_SUB, 5, 13, 2000, 3, 0, 0, 0));
		send_date(make_item(ACT_SUB, 31, 15, 2000, 3, 0, 0, 0));
		send_date(make_item(ACT_SUB, 31, 4, 2000, 3, 0, 0, 0));
		send_date(make_item(ACT_SUB, 1, 1, 1899, 3, 0, 0, 0));
		send_date(make_item(ACT_SUB, 1, 1, 1900, 1, 0, 0, 0));
		send_date(make_item(ACT_ADD, 31, 12, 2200, 1, 0, 0, 0));
		send_date(make_item(ACT_ADD, 1, 1, 2000, 131071, 0, 0, 0));
		send_date(make_item(ACT_CMP, 15, 6, 2000, 9, 15, 6, 2000));
		send_date(make_item(ACT_CMP, 1, 1, 1900, 0, 31, 12, 2200));
		send_date(make_item(ACT_CMP, 31, 12, 2200, 0, 1, 1, 1900));
		send_date(make_item(ACT_CMP, 1, 1, 2000, 0, 0, 1, 2000));
		send_date(make_item(2'd3, 1, 1, 2000, 5, 1, 1, 2000));
		drain_results();
	endtask

	task automatic test_full_year_span();
		write_year_limit(REG_MIN_YEAR, 12'd0);
		write_year_limit(REG_MAX_YEAR, 12'd4095);
		send_date(make_item(ACT_SUB, 1, 1, 0, 1, 0, 0, 0));
		send_date(make_item(ACT_SUB, 1, 3, 0, 0, 0, 0, 0));
		send_date(make_item(ACT_SUB, 1, 1, 0, 131071, 0, 0, 0));
		send_date(make_item(ACT_ADD, 31, 12, 4095, 1, 0, 0, 0));
		send_date(make_item(ACT_ADD, 29, 2, 4000, 0, 0, 0, 0));
		send_date(make_item(ACT_CMP, 1, 1, 0, 0, 31, 12, 4095));
		send_date(make_item(ACT_CMP, 31, 12, 4095, 0, 1, 1, 0));
		send_date(make_item(ACT_CMP, 1, 1, 100, 0, 1, 1, 400));
		drain_results();
	endtask

	task automatic test_crossed_limits();
		write_year_limit(REG_MIN_YEAR, 12'd2100);
		write_year_limit(REG_MAX_YEAR, 12'd2000);
		send_date(make_item(ACT_ADD, 1, 1, 2050, 1, 0, 0, 0));
		send_date(make_item(ACT_CMP, 1, 1, 2050, 0, 1, 1, 2050));
		drain_results();
	endtask

	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_off_cycles = 300;
		repeat (60) send_date(random_date_item());
		drain_results();
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.data = '0;
		item_ch.valid = 1'b0;
		item_ch.action = '0;
		item_ch.day = '0;
		item_ch.month = '0;
		item_ch.year = '0;
		item_ch.day_count = '0;
		item_ch.second_day = '0;
		item_ch.second_month = '0;
		item_ch.second_year = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_default_limits();
		run_random(150, 0, 0);
		test_full_year_span();
		run_random(200, 70, 0);
		write_year_limit(REG_MIN_YEAR, 12'd1582);
		write_year_limit(REG_MAX_YEAR, 12'd2400);
		run_random(200, 0, 70);
		run_random(200, 37, 37);
		test_backpressure();
		test_crossed_limits();
		write_year_limit(REG_MIN_YEAR, 12'd4095);
		write_year_limit(REG_MAX_YEAR, 12'd4095);
		run_random(50, 0, 0);

		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
